[sv/dho_pkg.sv]
package dho_pkg;

  // Input item: wheel speeds in mm/s, tick length in microseconds
  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [15:0] delta_time;
  } dho_in_t;

  // Result item: binary-angle heading, Q16.16 yaw rate in deg/s, update flag
  typedef struct packed {
    logic signed [31:0] heading_angle;
    logic signed [31:0] yaw_rate;
    logic               applied;
  } dho_out_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_WHEEL_TRACK = 1'b0,
    REG_YAW_ALPHA   = 1'b1
  } dho_reg_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;

  // round(2^32/(2*pi*1e6) * 2^16): heading counts per (mm/s * us / mm), Q16
  localparam logic [25:0] HeadK    = 26'd44798134;
  // round(180/pi * 2^32): degrees per radian, Q32
  localparam logic [37:0] YawK     = 38'd246083499208;
  localparam logic [16:0] AlphaOne = 17'h10000;

  // Quotient width of the two divisions (numerator already shifted by 16) and step counter width
  localparam int unsigned DivW     = 43;
  localparam int unsigned CntW     = 6;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_step;
    logic finish;
    logic filt1;
    logic filt2;
    logic publish;
  } dho_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic skip;
    logic div_last;
    logic need_filt;
    logic out_free;
  } dho_sts_t;

endpackage

[sv/dho_ctrl.sv]
module dho_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dho_pkg::dho_sts_t sts_i,
  output dho_pkg::dho_cmd_t cmd_o
);
  import dho_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL1  = 8'b0000_0010,
    S_MUL2  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_FILT1 = 8'b0010_0000,
    S_FILT2 = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Sequencer: unless skipped, multiply, divide, filter if rate held; publish
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.skip ? S_DONE : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = sts_i.need_filt ? S_FILT1 : S_DONE;
      end
      S_FILT1: begin
        cmd_o.filt1 = 1'b1;
        state_d     = S_FILT2;
      end
      S_FILT2: begin
        cmd_o.filt2 = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/dho_datapath.sv]
module dho_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dho_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dho_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  dho_pkg::dho_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dho_pkg::dho_out_t               out_data_o,
  input  dho_pkg::dho_cmd_t               cmd_i,
  output dho_pkg::dho_sts_t               sts_o
);
  import dho_pkg::*;

  // One restoring divide step: returns {remainder, quotient/dividend}
  function automatic logic [16+DivW-1:0] div_step(input logic [DivW-1:0] q,
                                                  input logic [15:0] rem,
                                                  input logic [15:0] den);
    logic [16:0] sh;
    logic [16:0] diff;
    logic [16+DivW-1:0] r;
    sh   = {rem, q[DivW-1]};
    diff = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      r = {diff[15:0], q[DivW-2:0], 1'b1};
    end else begin
      r = {sh[15:0], q[DivW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Configuration and architectural state
  logic [15:0]        track_q;
  logic [16:0]        alpha_q;
  logic [31:0]        heading_q, heading_d;
  logic signed [31:0] yaw_q, yaw_d;
  logic               have_q, have_d;
  logic               applied_q, applied_d;

  // Working registers
  logic [15:0]        mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [15:0]        dt_q, dt_d;
  logic [31:0]        p1_q, p1_d;
  logic [DivW-1:0]    hq_q, hq_d, yq_q, yq_d;
  logic [15:0]        hrem_q, hrem_d, yrem_q, yrem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [31:0] meas_q, meas_d;
  logic signed [49:0] prod_q, prod_d;
  dho_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Combinational helpers
  logic signed [16:0] diff_s;
  logic [16:0]        diff_abs;
  logic [54:0]        ynum;
  logic [58:0]        hnum;
  logic [16+DivW-1:0] hstep, ystep;
  logic [31:0]        step32;
  logic [38:0]        ymag;
  logic signed [31:0] meas;
  logic [16:0]        a_eff;
  logic [16:0]        a_inv;
  logic signed [50:0] fsum;
  logic signed [34:0] fy;

  assign diff_s   = {in_data_i.right_speed[15], in_data_i.right_speed}
                  - {in_data_i.left_speed[15], in_data_i.left_speed};
  assign diff_abs = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);

  assign ynum  = 55'(mag_q) * 55'(YawK) + 55'({track_q, 15'b0});
  assign hnum  = 59'(p1_q) * 59'(HeadK) + 59'({track_q, 15'b0});
  assign hstep = div_step(hq_q, hrem_q, track_q);
  assign ystep = div_step(yq_q, yrem_q, track_q);

  // Measured yaw rate with sign and saturation
  assign step32 = hq_q[31:0];
  assign ymag   = yq_q[38:0];
  always_comb begin
    if (neg_q) begin
      meas = (ymag >= 39'h0080000000) ? 32'sh80000000 : -$signed(ymag[31:0]);
    end else begin
      meas = (|ymag[38:31]) ? 32'sh7FFFFFFF : $signed(ymag[31:0]);
    end
  end

  // Filter weights and blend
  assign a_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign a_inv = AlphaOne - a_eff;
  assign fsum  = 51'(prod_q) + 51'($signed({1'b0, a_inv}) * yaw_q) + 51'sd32768;
  assign fy    = fsum[50:16];

  // Next-state logic driven by controller commands
  always_comb begin
    heading_d   = heading_q;
    yaw_d       = yaw_q;
    have_d      = have_q;
    applied_d   = applied_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    dt_d        = dt_q;
    p1_d        = p1_q;
    hq_d        = hq_q;
    yq_d        = yq_q;
    hrem_d      = hrem_q;
    yrem_d      = yrem_q;
    cnt_d       = cnt_q;
    meas_d      = meas_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      mag_d     = diff_abs[15:0];
      neg_d     = diff_s[16];
      dt_d      = in_data_i.delta_time;
      applied_d = 1'b0;
    end
    if (cmd_i.mul1) begin
      p1_d = 32'(mag_q) * 32'(dt_q);
      yq_d = {4'b0, ynum[54:16]};
    end
    if (cmd_i.mul2) begin
      hq_d   = hnum[58:16];
      hrem_d = '0;
      yrem_d = '0;
      cnt_d  = CntW'(DivW - 1);
    end
    if (cmd_i.div_step) begin
      {hrem_d, hq_d} = hstep;
      {yrem_d, yq_d} = ystep;
      cnt_d          = cnt_q - 1'b1;
    end
    if (cmd_i.finish) begin
      heading_d = heading_q + (neg_q ? (32'd0 - step32) : step32);
      meas_d    = meas;
      applied_d = 1'b1;
      if (!have_q) begin
        yaw_d  = meas;
        have_d = 1'b1;
      end
    end
    if (cmd_i.filt1) begin
      prod_d = $signed({1'b0, a_eff}) * meas_q;
    end
    if (cmd_i.filt2) begin
      if (fy > 35'sh00_7FFF_FFFF) begin
        yaw_d = 32'sh7FFFFFFF;
      end else if (fy < -35'sh00_8000_0000) begin
        yaw_d = 32'sh80000000;
      end else begin
        yaw_d = fy[31:0];
      end
    end
    if (cmd_i.publish) begin
      out_d.heading_angle = heading_q;
      out_d.yaw_rate      = yaw_q;
      out_d.applied       = applied_q;
      out_valid_d         = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q     <= '0;
      alpha_q     <= AlphaOne;
      heading_q   <= '0;
      yaw_q       <= '0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dho_reg_e'(cfg_idx_i))
          REG_WHEEL_TRACK: track_q <= cfg_wdata_i[15:0];
          REG_YAW_ALPHA:   alpha_q <= cfg_wdata_i;
          default:         ;
        endcase
      end
      heading_q   <= heading_d;
      yaw_q       <= yaw_d;
      have_q      <= have_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    applied_q <= applied_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    dt_q      <= dt_d;
    p1_q      <= p1_d;
    hq_q      <= hq_d;
    yq_q      <= yq_d;
    hrem_q    <= hrem_d;
    yrem_q    <= yrem_d;
    meas_q    <= meas_d;
    prod_q    <= prod_d;
    out_q     <= out_d;
  end

  assign sts_o.skip      = (in_data_i.delta_time == 16'd0) || (track_q == 16'd0);
  assign sts_o.div_last  = (cnt_q == '0);
  assign sts_o.need_filt = have_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/differential_heading_odometry_core.sv]
// Differential-drive heading odometry. Each accepted tick (left/right wheel speed
// in mm/s, interval in us) advances a 32-bit binary-angle heading by
// (right-left)*dt/track and updates a Q16.16 deg/s yaw rate, loaded directly on
// the first applied tick and blended with weight alpha (Q1.16) afterwards; every
// tick gives exactly one result. A tick with zero interval or zero track leaves
// the state alone and reports the current values with applied low. An applied
// tick goes through the 43-step radix-2 divider by the track width, two
// divisions running side by side, then the filter once a rate is held. One tick
// is worked on at a time; the output register lets the next tick be accepted
// while the previous result waits for transfer. Write configuration only while
// the block is idle.
module differential_heading_odometry_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dho_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dho_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dho_pkg::dho_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dho_pkg::dho_out_t            out_data_o
);
  import dho_pkg::*;

  dho_cmd_t cmd;
  dho_sts_t sts;

  dho_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dho_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[dv/tb_top.sv]
module tb_top;
  import dho_pkg::*;

  localparam int unsigned WdLimit     = 3000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned HoldCycles  = 400;
  localparam longint      YawMax      = 2147483647;
  localparam longint      YawMin      = -YawMax - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  dho_reg_e cfg_idx = REG_WHEEL_TRACK;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dho_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dho_out_t out_data;

  // pending ticks for the driver, predicted results for the monitor
  dho_in_t  tick_q[$];
  dho_out_t pose_q[$];

  // predictor state and its copy of the registers
  logic [15:0]        trk_mm = '0;
  logic [16:0]        alpha_q16 = AlphaOne;
  logic [31:0]        head_acc = '0;
  logic signed [31:0] yaw_acc = '0;
  logic               yaw_seeded = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  differential_heading_odometry_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance heading and yaw filter by one tick, return the reported pose
  function automatic dho_out_t advance_pose(dho_in_t t);
    longint             d;
    longint unsigned    mag;
    longint unsigned    den;
    longint unsigned    step;
    longint unsigned    ymag;
    logic [31:0]        step32;
    logic signed [31:0] meas;
    longint             a;
    longint             s;
    longint             y;
    dho_out_t           r;
    r.applied = 1'b0;
    if (t.delta_time != 0 && trk_mm != 0) begin
      d    = longint'($signed(t.right_speed)) - longint'($signed(t.left_speed));
      mag  = (d < 0) ? -d : d;
      den  = longint'(trk_mm) << 16;
      step = (mag * 64'(t.delta_time) * 64'(HeadK) + (den >> 1)) / den;
      step32 = step[31:0];
      if (d < 0) step32 = -step32;
      head_acc = head_acc + step32;
      // measured rate, rounded then saturated
      ymag = (mag * 64'(YawK) + (den >> 1)) / den;
      if (d < 0) begin
        meas = (ymag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(ymag[31:0]);
      end else begin
        meas = (ymag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : ymag[31:0];
      end
      if (!yaw_seeded) begin
        yaw_acc    = meas;
        yaw_seeded = 1'b1;
      end else begin
        a = (alpha_q16 > AlphaOne) ? longint'(AlphaOne) : longint'(alpha_q16);
        s = a * longint'(meas) + (65536 - a) * longint'(yaw_acc) + 32768;
        y = s >>> 16;
        if (y > YawMax) y = YawMax;
        if (y < YawMin) y = YawMin;
        yaw_acc = y[31:0];
      end
      r.applied = 1'b1;
    end
    r.heading_angle = head_acc;
    r.yaw_rate      = yaw_acc;
    return r;
  endfunction

  // Driver: offers queued ticks, predicts each accepted one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pose_q.push_back(advance_pose(in_data));
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer, drives random back-pressure
  always @(posedge clk or negedge rst_n) begin
    dho_out_t ref_pose;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result heading=%h yaw=%h applied=%b", $time,
                   out_data.heading_angle, out_data.yaw_rate, out_data.applied);
        end else begin
          ref_pose = pose_q.pop_front();
          if (out_data.heading_angle !== ref_pose.heading_angle) begin
            err_cnt++;
            $display("%0t: heading_angle exp %h got %h", $time,
                     ref_pose.heading_angle, out_data.heading_angle);
          end
          if (out_data.yaw_rate !== ref_pose.yaw_rate) begin
            err_cnt++;
            $display("%0t: yaw_rate exp %h got %h", $time,
                     ref_pose.yaw_rate, out_data.yaw_rate);
          end
          if (out_data.applied !== ref_pose.applied) begin
            err_cnt++;
            $display("%0t: applied exp %b got %b", $time,
                     ref_pose.applied, out_data.applied);
          end
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (hold_go && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdLimit) begin
      $display("[differential_heading_odometry_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_tick(int l, int r, int dt);
    dho_in_t t;
    t.left_speed  = 16'(l);
    t.right_speed = 16'(r);
    t.delta_time  = 16'(dt);
    tick_q.push_back(t);
  endtask

  // Mostly random speeds, with equal and near-equal pairs and edge intervals
  task automatic push_rand_tick();
    dho_in_t     t;
    int unsigned sel;
    t.left_speed = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) t.right_speed = t.left_speed;
    else if (sel < 30) t.right_speed = t.left_speed + 16'($urandom_range(200)) - 16'd100;
    else t.right_speed = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 5) t.delta_time = '0;
    else if (sel < 10) t.delta_time = 16'hFFFF;
    else if (sel < 15) t.delta_time = 16'd1;
    else t.delta_time = 16'($urandom);
    tick_q.push_back(t);
  endtask

  task automatic write_reg(dho_reg_e idx, logic [16:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WHEEL_TRACK: trk_mm = val[15:0];
      default:         alpha_q16 = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sender stays quiet until every predicted result has been seen
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || pose_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_idle(int unsigned snd, int unsigned rcv);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
  endtask

  initial begin
    logic [16:0] trk_val;
    logic [16:0] alpha_val;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset config: track zero, every tick ignored
    push_tick(100, -100, 1000);
    push_tick(0, 0, 0);
    drain();

    // normal track: zero interval, zero difference, full-scale speeds
    write_reg(REG_WHEEL_TRACK, 17'd150);
    push_tick(0, 0, 0);
    push_tick(500, 500, 1000);
    push_tick(-32768, 32767, 65535);
    push_tick(32767, -32768, 65535);
    push_tick(0, 1, 1);
    push_tick(1, 0, 1);
    push_tick(-1000, 2000, 20000);
    drain();

    // alpha zero freezes the rate, alpha above one acts as one
    write_reg(REG_YAW_ALPHA, 17'd0);
    push_tick(0, 3000, 500);
    drain();
    write_reg(REG_YAW_ALPHA, 17'h1FFFF);
    push_tick(3000, 0, 500);
    drain();

    // one-millimeter track: rate saturation both ways, heading step wraps
    write_reg(REG_WHEEL_TRACK, 17'd1);
    write_reg(REG_YAW_ALPHA, 17'd32768);
    push_tick(-32768, 32767, 65535);
    push_tick(32767, -32768, 65535);
    push_tick(0, 572, 100);
    push_tick(0, 573, 100);
    drain();

    write_reg(REG_WHEEL_TRACK, 17'd65535);
    write_reg(REG_YAW_ALPHA, AlphaOne);
    push_tick(-32768, 32767, 65535);
    push_tick(0, 1, 1);
    push_tick(32767, 32767, 7);
    drain();

    // receiver holds off while the sender keeps offering
    write_reg(REG_WHEEL_TRACK, 17'd300);
    write_reg(REG_YAW_ALPHA, 17'd40000);
    set_idle(0, 0);
    hold_go = 1'b1;
    repeat (20) push_rand_tick();
    drain();

    // random phases over idle modes and register settings
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(4))
        0:       trk_val = 17'($urandom_range(1, 8));
        1:       trk_val = 17'd65535;
        2:       trk_val = 17'($urandom);
        default: trk_val = 17'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(4))
        0:       alpha_val = 17'd0;
        1:       alpha_val = AlphaOne;
        2:       alpha_val = 17'h1FFFF;
        default: alpha_val = 17'($urandom);
      endcase
      write_reg(REG_WHEEL_TRACK, trk_val);
      write_reg(REG_YAW_ALPHA, alpha_val);
      case (p % 4)
        0:       set_idle(0, 0);
        1:       set_idle(85, 0);
        2:       set_idle(0, 85);
        default: set_idle(19, 19);
      endcase
      repeat (95) push_rand_tick();
      drain();
    end

    if (err_cnt == 0) begin
      $display("[differential_heading_odometry_core] OK");
    end else begin
      $display("[differential_heading_odometry_core] ERROR");
    end
    $finish;
  end

endmodule
